FILE: rtl/i2cms_pkg.sv
// Shared types and constants for the multi-bus I2C master bit sequencer.
// Depends on nothing; imported by the core and the top level.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int PIN_W     = 4;
    localparam int BUS_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int HP_W      = 20;
    localparam int BUS_COUNT = 4;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = HP_W'(12500);

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_INIT  = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [BUS_W-1:0]  bus;
        logic [BYTE_W-1:0] write_data;
        logic              send_ack;
        logic [PIN_W-1:0]  sda_levels;
    } item_t;

    typedef struct packed {
        logic [PIN_W-1:0]  scl_enable_bits;
        logic [PIN_W-1:0]  scl_level_bits;
        logic [PIN_W-1:0]  sda_pull_bits;
        logic [PIN_W-1:0]  sda_level_bits;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              acked;
        logic              stuck_error;
        logic              rejected;
    } result_t;

endpackage

FILE: rtl/i2cms_pipe_reg.sv
// Single-entry pipeline register with valid/ready; full throughput.
// Used for the input stage and the result stage of the sequencer.
`timescale 1ns / 1ps

module i2cms_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: rtl/i2cms_core.sv
// Sequencer state and per-item step logic: pin registers, half-period counter,
// command program, status. Depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2cms_core
    import i2cms_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [HP_W-1:0] cfg_wdata,
    input  logic            fire,
    input  item_t           item,
    output result_t         result
);

    typedef enum logic [3:0] {
        ST_IDLE         = 4'd0,
        ST_INIT_W2      = 4'd1,
        ST_INIT_CHECK   = 4'd2,
        ST_START_PULL   = 4'd3,
        ST_DONE         = 4'd4,
        ST_STOP_HIGH    = 4'd5,
        ST_STOP_RELEASE = 4'd6,
        ST_WR_RISE      = 4'd8,
        ST_WR_NEXT      = 4'd9,
        ST_WR_ACKREL    = 4'd10,
        ST_WR_ACKSAMPLE = 4'd11,
        ST_RD_RELEASE   = 4'd12,
        ST_RD_RISE      = 4'd13,
        ST_RD_SAMPLE    = 4'd14,
        ST_RD_ACKHIGH   = 4'd15
    } step_t;

    function automatic logic [PIN_W-1:0] put_bit(input logic [PIN_W-1:0] pins,
                                                  input logic [PIN_W-1:0] mask,
                                                  input logic on);
        put_bit = on ? (pins | mask) : (pins & ~mask);
    endfunction

    logic [HP_W-1:0]   half_period_reg;
    step_t             step_reg, step_next;
    logic [HP_W-1:0]   cnt_reg, cnt_next, cnt_inc, period;
    logic [PIN_W-1:0]  scl_en_reg, scl_en_next;
    logic [PIN_W-1:0]  scl_lvl_reg, scl_lvl_next;
    logic [PIN_W-1:0]  sda_pull_reg, sda_pull_next;
    logic [PIN_W-1:0]  sda_lvl_reg, sda_lvl_next;
    logic [2:0]        bit_reg, bit_next, bit_dec;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] rx_reg, rx_next;
    logic [BUS_W-1:0]  bus_reg, bus_next, cur_bus;
    logic              ack_req_reg, ack_req_next;
    logic              acked_reg, acked_next;
    logic              stuck_reg, stuck_next;
    logic              busy, is_cmd, in_range, sda_in, done, rejected;
    logic [PIN_W-1:0]  mask;
    op_t               op;

    always_comb
    begin
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        scl_en_next   = scl_en_reg;
        scl_lvl_next  = scl_lvl_reg;
        sda_pull_next = sda_pull_reg;
        sda_lvl_next  = sda_lvl_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        rx_next       = rx_reg;
        bus_next      = bus_reg;
        ack_req_next  = ack_req_reg;
        acked_next    = acked_reg;
        stuck_next    = stuck_reg;
        done          = 1'b0;
        rejected      = 1'b0;

        op       = op_t'(item.operation);
        period   = (half_period_reg == '0) ? HP_W'(1) : half_period_reg;
        busy     = (step_reg != ST_IDLE);
        is_cmd   = (op >= OP_INIT) && (op <= OP_READ);
        cur_bus  = busy ? bus_reg : item.bus;
        in_range = (int'(cur_bus) < BUS_COUNT);
        mask     = in_range ? (PIN_W'(1) << cur_bus) : '0;
        sda_in   = in_range ? item.sda_levels[cur_bus] : 1'b1;
        cnt_inc  = cnt_reg + HP_W'(1);
        bit_dec  = bit_reg - 3'd1;

        if (busy)
        begin
            rejected = is_cmd;
            if (cnt_inc >= period)
            begin
                cnt_next = '0;
                unique case (step_reg)
                    ST_INIT_W2:
                    begin
                        step_next = ST_INIT_CHECK;
                    end
                    ST_INIT_CHECK:
                    begin
                        stuck_next = !sda_in;
                        step_next  = ST_IDLE;
                        done       = 1'b1;
                    end
                    ST_START_PULL:
                    begin
                        sda_pull_next = put_bit(sda_pull_reg, mask, 1'b1);
                        step_next     = ST_DONE;
                    end
                    ST_STOP_HIGH:
                    begin
                        sda_pull_next = put_bit(sda_pull_reg, mask, 1'b1);
                        scl_lvl_next  = put_bit(scl_lvl_reg, mask, 1'b1);
                        step_next     = ST_STOP_RELEASE;
                    end
                    ST_STOP_RELEASE:
                    begin
                        sda_pull_next = put_bit(sda_pull_reg, mask, 1'b0);
                        step_next     = ST_DONE;
                    end
                    ST_WR_RISE:
                    begin
                        scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b1);
                        step_next    = ST_WR_NEXT;
                    end
                    ST_WR_NEXT:
                    begin
                        scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b0);
                        if (bit_reg != 3'd0)
                        begin
                            bit_next      = bit_dec;
                            sda_pull_next = put_bit(sda_pull_reg, mask, !shift_reg[bit_dec]);
                            step_next     = ST_WR_RISE;
                        end
                        else
                        begin
                            step_next = ST_WR_ACKREL;
                        end
                    end
                    ST_WR_ACKREL:
                    begin
                        sda_pull_next = put_bit(sda_pull_reg, mask, 1'b0);
                        scl_lvl_next  = put_bit(scl_lvl_reg, mask, 1'b1);
                        step_next     = ST_WR_ACKSAMPLE;
                    end
                    ST_WR_ACKSAMPLE:
                    begin
                        acked_next = !sda_in;
                        bit_next   = 3'd7;
                        step_next  = ST_IDLE;
                        done       = 1'b1;
                    end
                    ST_RD_RELEASE:
                    begin
                        sda_pull_next = put_bit(sda_pull_reg, mask, 1'b0);
                        scl_lvl_next  = put_bit(scl_lvl_reg, mask, 1'b0);
                        step_next     = ST_RD_RISE;
                    end
                    ST_RD_RISE:
                    begin
                        scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b1);
                        step_next    = ST_RD_SAMPLE;
                    end
                    ST_RD_SAMPLE:
                    begin
                        shift_next[bit_reg] = shift_reg[bit_reg] | sda_in;
                        scl_lvl_next        = put_bit(scl_lvl_reg, mask, 1'b0);
                        if (bit_reg != 3'd0)
                        begin
                            bit_next  = bit_dec;
                            step_next = ST_RD_RISE;
                        end
                        else
                        begin
                            if (ack_req_reg)
                            begin
                                sda_pull_next = put_bit(sda_pull_reg, mask, 1'b1);
                            end
                            step_next = ST_RD_ACKHIGH;
                        end
                    end
                    ST_RD_ACKHIGH:
                    begin
                        scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b1);
                        rx_next      = shift_reg;
                        bit_next     = 3'd7;
                        step_next    = ST_DONE;
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                        done      = 1'b1;
                    end
                endcase
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
        else if (is_cmd)
        begin
            bus_next = item.bus;
            cnt_next = '0;
            unique case (op)
                OP_INIT:
                begin
                    scl_lvl_next  = put_bit(scl_lvl_reg, mask, 1'b1);
                    scl_en_next   = put_bit(scl_en_reg, mask, 1'b1);
                    sda_lvl_next  = put_bit(sda_lvl_reg, mask, 1'b0);
                    sda_pull_next = put_bit(sda_pull_reg, mask, 1'b0);
                    step_next     = ST_INIT_W2;
                end
                OP_START:
                begin
                    scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b1);
                    step_next    = ST_START_PULL;
                end
                OP_STOP:
                begin
                    scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b0);
                    step_next    = ST_STOP_HIGH;
                end
                OP_WRITE:
                begin
                    shift_next    = item.write_data;
                    bit_next      = 3'd7;
                    scl_lvl_next  = put_bit(scl_lvl_reg, mask, 1'b0);
                    sda_pull_next = put_bit(sda_pull_reg, mask, !item.write_data[7]);
                    step_next     = ST_WR_RISE;
                end
                default:
                begin
                    shift_next   = '0;
                    bit_next     = 3'd7;
                    ack_req_next = item.send_ack;
                    scl_lvl_next = put_bit(scl_lvl_reg, mask, 1'b0);
                    step_next    = ST_RD_RELEASE;
                end
            endcase
        end

        result.scl_enable_bits = scl_en_next;
        result.scl_level_bits  = scl_lvl_next;
        result.sda_pull_bits   = sda_pull_next;
        result.sda_level_bits  = sda_lvl_next;
        result.busy_res        = (step_next != ST_IDLE);
        result.done_res        = done;
        result.read_data       = rx_next;
        result.acked           = acked_next;
        result.stuck_error     = stuck_next;
        result.rejected        = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            step_reg        <= ST_IDLE;
            cnt_reg         <= '0;
            scl_en_reg      <= '0;
            scl_lvl_reg     <= '0;
            sda_pull_reg    <= '0;
            sda_lvl_reg     <= '0;
            bit_reg         <= 3'd7;
            shift_reg       <= '0;
            rx_reg          <= '0;
            bus_reg         <= '0;
            ack_req_reg     <= 1'b0;
            acked_reg       <= 1'b0;
            stuck_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (fire)
            begin
                step_reg     <= step_next;
                cnt_reg      <= cnt_next;
                scl_en_reg   <= scl_en_next;
                scl_lvl_reg  <= scl_lvl_next;
                sda_pull_reg <= sda_pull_next;
                sda_lvl_reg  <= sda_lvl_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                rx_reg       <= rx_next;
                bus_reg      <= bus_next;
                ack_req_reg  <= ack_req_next;
                acked_reg    <= acked_next;
                stuck_reg    <= stuck_next;
            end
        end
    end

    a_done_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.done_res) |-> (step_reg != ST_IDLE))
        else $error("command finished without a running program");

    a_reject_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.rejected) |-> (step_reg != ST_IDLE))
        else $error("command rejected while idle");

    a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("half-period counter running while idle");

    a_idle_bit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_IDLE) |-> (bit_reg == 3'd7))
        else $error("bit index not rewound at end of program");

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
// Top level of the multi-bus I2C master bit sequencer: stream ports,
// input stage, step core, result stage. Depends on i2cms_pkg and its submodules.
//
//  Channel    Direction  Handshake                    Payload
//  s_axis     in         s_axis_tvalid/s_axis_tready  tuser: operation; tdata: item fields
//  m_axis     out        m_axis_tvalid/m_axis_tready  tdata: pin bits and status
//  cfg        in         cfg_we (no wait)             cfg_wdata: half_period_cycles
//
// Flow: one result per item, one item per cycle while no result is held back;
// an item waits in the input register and is then stepped into the result
// register, from which its result transfers out.
// Bus timing comes from items, not clocks: each wait of a program spans
// half_period_cycles items (zero behaves as one).
// Reset clears the pin registers, the program state and the stage valids;
// the half period returns to 12500.
// Stalls: a held result back-pressures the core; the input stage still takes
// a transfer when the result register is free or being drained.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // [1:0] bus, [9:2] write_data, [10] send_ack, [14:11] sda_levels, [15] ignored
    input  logic [15:0]     s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]      s_axis_tuser,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // [3:0] scl_enable_bits, [7:4] scl_level_bits, [11:8] sda_pull_bits,
    // [15:12] sda_level_bits, [16] busy_res, [17] done_res, [25:18] read_data,
    // [26] acked, [27] stuck_error, [28] rejected, [31:29] zero
    output logic [31:0]     m_axis_tdata,
    input  logic            cfg_we,
    input  logic [HP_W-1:0] cfg_wdata
);

    item_t   in_item, stage_item;
    result_t core_result, out_result;
    logic    stage_valid, stage_ready;
    logic    fire;

    // Unpack the slave-side transfer into the item fields.
    always_comb
    begin
        in_item.operation  = s_axis_tuser;
        in_item.bus        = s_axis_tdata[1:0];
        in_item.write_data = s_axis_tdata[9:2];
        in_item.send_ack   = s_axis_tdata[10];
        in_item.sda_levels = s_axis_tdata[14:11];
    end

    // Input register: holds the accepted item until the core consumes it.
    i2cms_pipe_reg #(
        .WIDTH ($bits(item_t))
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (stage_valid),
        .out_ready (stage_ready),
        .out_data  (stage_item)
    );

    // The core commits its state exactly when the result register takes the result.
    assign fire = stage_valid && stage_ready;

    i2cms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (stage_item),
        .result    (core_result)
    );

    // Result register: parts the core from the master-side back-pressure.
    i2cms_pipe_reg #(
        .WIDTH ($bits(result_t))
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid),
        .in_ready  (stage_ready),
        .in_data   (core_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // Pack the result fields, scl_enable_bits in the lowest bits.
    assign m_axis_tdata = {3'b000,
                           out_result.rejected,
                           out_result.stuck_error,
                           out_result.acked,
                           out_result.read_data,
                           out_result.done_res,
                           out_result.busy_res,
                           out_result.sda_level_bits,
                           out_result.sda_pull_bits,
                           out_result.scl_level_bits,
                           out_result.scl_enable_bits};

endmodule
